@@ hdl/insert_delete_byte_buffer_top_defines.svh @@
// Assertion macros used by the insert/delete byte buffer sequencer.
`ifndef INSERT_DELETE_BYTE_BUFFER_TOP_DEFINES_SVH
`define INSERT_DELETE_BYTE_BUFFER_TOP_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define IBB_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define IBB_ASSERT(lbl, prop, msg) `IBB_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ hdl/ibb_pkg.sv @@
// Types and constants shared by the insert/delete byte buffer modules.
`timescale 1ns / 1ps

package ibb_pkg;

  // Field widths of the request and result beats.
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned POS_W  = 9;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned LEN_W  = 9;

  // Default capacity in bytes.
  localparam int unsigned IBB_DEPTH = 256;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Port enables from the sequencer to the byte memory.
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

@@ hdl/ibb_mem.sv @@
// Byte memory with one write port and one registered read port.
`timescale 1ns / 1ps

module ibb_mem import ibb_pkg::*; #(
  parameter int unsigned DEPTH = IBB_DEPTH,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  mem_ctl_t          mem_ctl_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Synchronous write and read; the read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (mem_ctl_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/ibb_ctrl.sv @@
// Request sequencer: range checks, length tracking, memory shift walk and result register.
`timescale 1ns / 1ps
`include "insert_delete_byte_buffer_top_defines.svh"

module ibb_ctrl import ibb_pkg::*; #(
  parameter int unsigned DEPTH = IBB_DEPTH,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [DATA_W-1:0] value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [STAT_W-1:0] status_o,
  output logic [DATA_W-1:0] read_data_o,
  output logic [LEN_W-1:0]  length_now_o,
  output mem_ctl_t          mem_ctl_o,
  output logic [AW-1:0]     mem_waddr_o,
  output logic [DATA_W-1:0] mem_wdata_o,
  output logic [AW-1:0]     mem_raddr_o,
  input  logic [DATA_W-1:0] mem_rdata_i
);

  localparam int unsigned LW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (LW > POS_W) ? LW : POS_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_READ   = 4'b0010,
    ST_SHIFT  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [LW-1:0]     len_q, len_d;
  cmd_e              cmd_q, cmd_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [AW-1:0]     src_q, src_d;
  logic [LW-1:0]     cnt_q, cnt_d;
  logic              wb_valid_q, wb_valid_d;
  logic [AW-1:0]     wb_addr_q, wb_addr_d;
  status_e           res_status_q, res_status_d;
  logic [DATA_W-1:0] res_data_q, res_data_d;
  logic              out_valid_q, out_valid_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [DATA_W-1:0] rdata_q, rdata_d;
  logic [LEN_W-1:0]  length_q, length_d;

  logic          accept;
  logic [CW-1:0] pos_ext, len_ext;
  logic          in_range, ins_range, full;

  // Position checks against the current length.
  assign pos_ext   = CW'(position_i);
  assign len_ext   = CW'(len_q);
  assign in_range  = pos_ext < len_ext;
  assign ins_range = pos_ext <= len_ext;
  assign full      = len_ext == CW'(DEPTH);

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Sequencer and memory port control.
  always_comb begin
    state_d      = state_q;
    len_d        = len_q;
    cmd_d        = cmd_q;
    pos_d        = pos_q;
    val_d        = val_q;
    src_d        = src_q;
    cnt_d        = cnt_q;
    wb_valid_d   = wb_valid_q;
    wb_addr_d    = wb_addr_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    out_valid_d  = out_valid_q;
    status_d     = status_q;
    rdata_d      = rdata_q;
    length_d     = length_q;
    mem_ctl_o    = '0;
    mem_waddr_o  = '0;
    mem_wdata_o  = '0;
    mem_raddr_o  = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d        = cmd_e'(command_i);
          pos_d        = AW'(position_i);
          val_d        = value_i;
          res_data_d   = '0;
          res_status_d = STATUS_OK;
          wb_valid_d   = 1'b0;
          state_d      = ST_FINISH;
          case (cmd_e'(command_i))
            CMD_WRITE: begin
              if (in_range) begin
                mem_ctl_o.we = 1'b1;
                mem_waddr_o  = AW'(position_i);
                mem_wdata_o  = value_i;
              end else begin
                res_status_d = STATUS_RANGE;
              end
            end
            CMD_READ: begin
              if (in_range) begin
                mem_ctl_o.re = 1'b1;
                mem_raddr_o  = AW'(position_i);
                state_d      = ST_READ;
              end else begin
                res_status_d = STATUS_RANGE;
              end
            end
            CMD_INSERT: begin
              if (!ins_range) begin
                res_status_d = STATUS_RANGE;
              end else if (full) begin
                res_status_d = STATUS_FULL;
              end else begin
                len_d   = len_q + LW'(1);
                cnt_d   = LW'(len_ext - pos_ext);
                src_d   = AW'(len_ext - CW'(1));
                state_d = ST_SHIFT;
              end
            end
            CMD_DELETE: begin
              if (!in_range) begin
                res_status_d = STATUS_RANGE;
              end else begin
                len_d   = len_q - LW'(1);
                cnt_d   = LW'(len_ext - pos_ext - CW'(1));
                src_d   = AW'(pos_ext + CW'(1));
                state_d = ST_SHIFT;
              end
            end
            default: begin
              res_status_d = STATUS_RANGE;
            end
          endcase
        end
      end

      ST_READ: begin
        res_data_d = mem_rdata_i;
        state_d    = ST_FINISH;
      end

      // One byte moves per cycle: read the source, write it one place over next cycle.
      ST_SHIFT: begin
        if (wb_valid_q) begin
          mem_ctl_o.we = 1'b1;
          mem_waddr_o  = wb_addr_q;
          mem_wdata_o  = mem_rdata_i;
        end
        if (cnt_q != '0) begin
          mem_ctl_o.re = 1'b1;
          mem_raddr_o  = src_q;
          wb_valid_d   = 1'b1;
          cnt_d        = cnt_q - LW'(1);
          if (cmd_q == CMD_INSERT) begin
            wb_addr_d = src_q + AW'(1);
            src_d     = src_q - AW'(1);
          end else begin
            wb_addr_d = src_q - AW'(1);
            src_d     = src_q + AW'(1);
          end
        end else begin
          wb_valid_d = 1'b0;
          if (!wb_valid_q) begin
            if (cmd_q == CMD_INSERT) begin
              mem_ctl_o.we = 1'b1;
              mem_waddr_o  = pos_q;
              mem_wdata_o  = val_q;
            end
            state_d = ST_FINISH;
          end
        end
      end

      // Hand the result to the output register once it is free.
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          rdata_d     = res_data_q;
          length_d    = LEN_W'(len_q);
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      cnt_q       <= '0;
      wb_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      wb_valid_q  <= wb_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    pos_q        <= pos_d;
    val_q        <= val_d;
    src_q        <= src_d;
    wb_addr_q    <= wb_addr_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    status_q     <= status_d;
    rdata_q      <= rdata_d;
    length_q     <= length_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign read_data_o  = rdata_q;
  assign length_now_o = length_q;

  // Checks on the sequencer.
  `IBB_ASSERT(a_len_bound, len_q <= LW'(DEPTH), "length exceeds capacity")
  `IBB_ASSERT(a_ins_len, accept && (command_i == CMD_INSERT) && ins_range && !full |=> len_q == $past(len_q) + LW'(1), "insert did not raise length")
  `IBB_ASSERT(a_mem_port, mem_ctl_o.we && mem_ctl_o.re |-> mem_waddr_o != mem_raddr_o, "read and write hit the same entry")
  `IBB_ASSERT(a_out_rise, $rose(out_valid_q) |-> $past(state_q == ST_FINISH), "result raised outside finish")
  `IBB_ASSERT(a_shift_done, (state_q == ST_SHIFT) && (state_d == ST_FINISH) |-> (cnt_q == '0) && !wb_valid_q, "shift left early")

endmodule

@@ hdl/insert_delete_byte_buffer_top.sv @@
// Sequencing: a write or a rejected request goes from idle to the finish state, a read through
// the read state first, and an insert or delete through the shift state, which moves one byte
// per cycle; the finish state loads the result register once it is free.
// A new request is taken only in the idle state, after the result of the last one is registered;
// the byte memory has one write port and one registered read port.
// Reset clears the length and the handshake state; memory contents are left as they are.
`timescale 1ns / 1ps

module insert_delete_byte_buffer_top import ibb_pkg::*; #(
  parameter int unsigned DEPTH = IBB_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [DATA_W-1:0] value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [STAT_W-1:0] status_o,
  output logic [DATA_W-1:0] read_data_o,
  output logic [LEN_W-1:0]  length_now_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  mem_ctl_t          mem_ctl;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  // Request sequencer.
  ibb_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .read_data_o  (read_data_o),
    .length_now_o (length_now_o),
    .mem_ctl_o    (mem_ctl),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  // Byte storage.
  ibb_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .mem_ctl_i (mem_ctl),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_i   (mem_raddr),
    .rdata_o   (mem_rdata)
  );

endmodule
